/* hw/rtl/nns3d_pkg.sv */
// Shared types and constants for the nearest node search block.
// Used by the cell, the top level and the port checker; depends on nothing.
`default_nettype none

package nns3d_pkg;

	// Field widths
	localparam int COORD_W = 24;            // signed Q20.4 coordinate
	localparam int AXES    = 3;             // x, y, z
	localparam int MAG_W   = COORD_W + 1;   // magnitude of a coordinate difference
	localparam int DIST_W  = 50;            // squared distance, Q.8
	localparam int NCNT_W  = 11;            // node_count register
	localparam int NIDX_W  = 10;            // node_index input field
	localparam int OIDX_W  = 10;            // nearest_index output field
	localparam int CFG_IDX_W = 1;

	// Reset values of the configuration registers
	localparam logic [NCNT_W-1:0] NODE_COUNT_RST = '0;
	localparam logic [DIST_W-1:0] MAX_SQ_RST     = 50'd163840000;

	// Command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NODE_COUNT = 1'b0,
		REG_MAX_SQ     = 1'b1
	} cfg_reg_t;

	typedef logic [COORD_W-1:0]   coord_t;
	typedef coord_t [AXES-1:0]    pos_t;    // [0] = x, [1] = y, [2] = z
	typedef logic [DIST_W-1:0]    dist_t;

	// Control that travels with each entry down the row of cells
	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

endpackage : nns3d_pkg

`default_nettype wire

/* hw/rtl/nns3d_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the node position table.
`default_nettype none

module nns3d_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 1024
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule : nns3d_ram

`default_nettype wire

/* hw/rtl/nns3d_cell.sv */
// One cell of the distance row: adds the squared difference on one axis
// to the running sum and hands everything to the next cell. Uses nns3d_pkg.
`default_nettype none

module nns3d_cell #(
	parameter int AXIS  = 0,
	parameter int IDX_W = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nns3d_pkg::tag_t     tag_in,
	input  logic [IDX_W-1:0]    idx_in,
	input  nns3d_pkg::pos_t     node_in,
	input  nns3d_pkg::coord_t   query,
	input  nns3d_pkg::dist_t    sum_in,
	output nns3d_pkg::tag_t     tag_out,
	output logic [IDX_W-1:0]    idx_out,
	output nns3d_pkg::pos_t     node_out,
	output nns3d_pkg::dist_t    sum_out
);
	import nns3d_pkg::*;

	logic [MAG_W-1:0] diff;
	logic [MAG_W-1:0] mag;

	tag_t             tag_s1, tag_s2, tag_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	pos_t             node_s1, node_s2, node_s3;
	dist_t            sum_s1, sum_s2, sum_s3;
	logic [MAG_W-1:0] mag_s1;
	dist_t            sq_s2;

	// Sign-extend both coordinates and take the magnitude of the difference
	assign diff = {node_in[AXIS][COORD_W-1], node_in[AXIS]} - {query[COORD_W-1], query};
	assign mag  = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;

	// Tags advance every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// Stage 1: difference magnitude
	always_ff @(posedge clk) begin
		idx_s1  <= idx_in;
		node_s1 <= node_in;
		sum_s1  <= sum_in;
		mag_s1  <= mag;
	end

	// Stage 2: square
	always_ff @(posedge clk) begin
		idx_s2  <= idx_s1;
		node_s2 <= node_s1;
		sum_s2  <= sum_s1;
		sq_s2   <= DIST_W'(mag_s1) * DIST_W'(mag_s1);
	end

	// Stage 3: accumulate
	always_ff @(posedge clk) begin
		idx_s3  <= idx_s2;
		node_s3 <= node_s2;
		sum_s3  <= sum_s2 + sq_s2;
	end

	assign tag_out  = tag_s3;
	assign idx_out  = idx_s3;
	assign node_out = node_s3;
	assign sum_out  = sum_s3;

endmodule : nns3d_cell

`default_nettype wire

/* hw/rtl/nearest_node_search_3d.sv */
// Nearest node search over a table of 3-D node positions: top level.
// Uses nns3d_pkg, nns3d_ram and nns3d_cell.
//
// A load item writes one node position into the table; loads to an index
// at or above MAX_NODES are dropped. A query item scans entries 0 to
// min(node_count, MAX_NODES)-1 and returns one result item: found, plus
// the index of the nearest entry (the first on a tie) if its squared
// distance is strictly below the running best, which starts at max_sq_distance.
// The scan reads one entry per cycle from the single read port of the node
// table and passes each through the memory read, a row of three cells of
// three stages each, the compare and the output register; a query with an
// empty scan goes straight to the output register. The block takes no item
// during a query, and its result waits in the output register without
// holding up the next item. Scanning an entry that was never loaded gives
// an undefined result.
`default_nettype none

module nearest_node_search_3d #(
	parameter int MAX_NODES = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// item input
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  command,
	input  logic [nns3d_pkg::NIDX_W-1:0]          node_index,
	input  logic signed [nns3d_pkg::COORD_W-1:0]  pos_x,
	input  logic signed [nns3d_pkg::COORD_W-1:0]  pos_y,
	input  logic signed [nns3d_pkg::COORD_W-1:0]  pos_z,
	// result output
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  found,
	output logic [nns3d_pkg::OIDX_W-1:0]          nearest_index,
	// configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [nns3d_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nns3d_pkg::DIST_W-1:0]          cfg_data
);
	import nns3d_pkg::*;

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CW = $clog2(MAX_NODES + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t              state_q;
	logic [NCNT_W-1:0]   node_count_q;
	dist_t               max_sq_q;
	pos_t                query_q;
	logic [CW-1:0]       lim_q;
	logic [CW-1:0]       rd_cnt_q;
	dist_t               best_q;
	logic [AW-1:0]       best_idx_q;
	logic                hit_q;
	logic                out_valid_q;
	logic                out_found_q;
	logic [OIDX_W-1:0]   out_idx_q;

	logic                in_acc;
	logic                load_en;
	logic                query_start;
	logic [31:0]         cnt_ext;
	logic [31:0]         nidx_ext;
	logic [31:0]         best_idx_ext;
	logic [CW-1:0]       lim_d;
	logic                issue;
	logic                issue_last;
	logic                deliver;
	pos_t                in_pos;
	pos_t                rd_data;

	tag_t                tag_rd_s1;
	logic [AW-1:0]       idx_rd_s1;

	tag_t                tag_c  [AXES+1];
	logic [AW-1:0]       idx_c  [AXES+1];
	pos_t                node_c [AXES+1];
	dist_t               sum_c  [AXES+1];

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign in_pos    = {pos_z, pos_y, pos_x};

	// Load address range check and scan length
	assign nidx_ext    = 32'(node_index);
	assign load_en     = in_acc && (command == CMD_LOAD) && (nidx_ext < 32'(MAX_NODES));
	assign query_start = in_acc && (command == CMD_QUERY);
	assign cnt_ext     = 32'(node_count_q);
	assign lim_d       = (cnt_ext > 32'(MAX_NODES)) ? CW'(MAX_NODES) : cnt_ext[CW-1:0];

	// Read issue during the scan
	assign issue      = (state_q == ST_SCAN) && (rd_cnt_q < lim_q);
	assign issue_last = (rd_cnt_q + CW'(1)) == lim_q;
	assign deliver    = (state_q == ST_HOLD) && (!out_valid_q || out_ready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			max_sq_q     <= MAX_SQ_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_NODE_COUNT: node_count_q <= cfg_data[NCNT_W-1:0];
				REG_MAX_SQ:     max_sq_q     <= cfg_data;
				default:        ;
			endcase
		end
	end

	// Node position table
	nns3d_ram #(
		.WIDTH ($bits(pos_t)),
		.DEPTH (MAX_NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (load_en),
		.waddr (nidx_ext[AW-1:0]),
		.wdata (in_pos),
		.re    (issue),
		.raddr (rd_cnt_q[AW-1:0]),
		.rdata (rd_data)
	);

	// Sequencer: idle, scan, hold result until the output slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= '0;
			lim_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (query_start) begin
						rd_cnt_q <= '0;
						lim_q    <= lim_d;
						state_q  <= (lim_d == '0) ? ST_HOLD : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (tag_c[AXES].valid && tag_c[AXES].last) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (deliver) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the query position for the whole scan
	always_ff @(posedge clk) begin
		if (query_start) begin
			query_q <= in_pos;
		end
	end

	// Tag the entry whose read data arrives next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_rd_s1 <= '0;
		end else begin
			tag_rd_s1.valid <= issue;
			tag_rd_s1.last  <= issue && issue_last;
		end
	end

	always_ff @(posedge clk) begin
		idx_rd_s1 <= rd_cnt_q[AW-1:0];
	end

	// Row of cells, one per axis
	assign tag_c[0]  = tag_rd_s1;
	assign idx_c[0]  = idx_rd_s1;
	assign node_c[0] = rd_data;
	assign sum_c[0]  = '0;

	for (genvar k = 0; k < AXES; k++) begin : g_cell
		nns3d_cell #(
			.AXIS  (k),
			.IDX_W (AW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tag_in   (tag_c[k]),
			.idx_in   (idx_c[k]),
			.node_in  (node_c[k]),
			.query    (query_q[k]),
			.sum_in   (sum_c[k]),
			.tag_out  (tag_c[k+1]),
			.idx_out  (idx_c[k+1]),
			.node_out (node_c[k+1]),
			.sum_out  (sum_c[k+1])
		);
	end

	// Keep the first strict minimum
	always_ff @(posedge clk) begin
		if (query_start) begin
			best_q     <= max_sq_q;
			best_idx_q <= '0;
			hit_q      <= 1'b0;
		end else if (tag_c[AXES].valid && (sum_c[AXES] < best_q)) begin
			best_q     <= sum_c[AXES];
			best_idx_q <= idx_c[AXES];
			hit_q      <= 1'b1;
		end
	end

	assign best_idx_ext = 32'(best_idx_q);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (deliver) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (deliver) begin
			out_found_q <= hit_q;
			out_idx_q   <= best_idx_ext[OIDX_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = out_found_q;
	assign nearest_index = out_idx_q;

endmodule : nearest_node_search_3d

`default_nettype wire

/* hw/rtl/nns3d_checker.sv */
// Port-level checks for the nearest node search block, bound to its top level.
// Uses nns3d_pkg for field widths.
`default_nettype none

module nns3d_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             command,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic                             found,
	input logic [nns3d_pkg::OIDX_W-1:0]     nearest_index
);
	import nns3d_pkg::*;

	// A stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(nearest_index))
		else $error("result item changed while stalled");

	// A miss reports index zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> nearest_index == '0)
		else $error("not-found result with nonzero index");

	// A load leaves the block ready for the next item
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_LOAD |=> in_ready)
		else $error("block busy after a load");

	// A query occupies the block
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_QUERY |=> !in_ready)
		else $error("block ready right after a query");

	// A new result item only comes out of a busy period
	a_result_after_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result item without a query in progress");

endmodule : nns3d_checker

bind nearest_node_search_3d nns3d_checker u_nns3d_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.command       (command),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.found         (found),
	.nearest_index (nearest_index)
);

`default_nettype wire
